### sv/bcc_pkg.sv
// Shared types, codes and BCD helpers for the BCD calendar clock with serial readout.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bcc_pkg;

  // Item action codes
  localparam logic ActTick = 1'b0;
  localparam logic ActCtrl = 1'b1;

  // Control codes
  localparam logic [7:0] CtlLoad    = 8'h00;
  localparam logic [7:0] CtlShift   = 8'h02;
  localparam logic [7:0] CtlRestart = 8'h04;

  localparam int unsigned ImageBits = 48;
  localparam logic [5:0]  IdxMax    = 6'd63;

  // Reset values
  localparam logic [7:0] TpsReset   = 8'd60;
  localparam logic [7:0] DayReset   = 8'h09;
  localparam logic [2:0] DowReset   = 3'd1;
  localparam logic [3:0] MonthReset = 4'd9;
  localparam logic [7:0] YearReset  = 8'h73;

  // Wrap limits
  localparam logic [7:0] SecLimit  = 8'h60;
  localparam logic [7:0] HourLimit = 8'h24;
  localparam logic [7:0] YearWrap  = 8'hA0;
  localparam logic [3:0] MonthWrap = 4'd13;
  localparam logic [2:0] DowLast   = 3'd6;

  typedef struct packed {
    logic       action;
    logic [7:0] control_code;
  } bcc_in_t;

  typedef struct packed {
    logic data_bit;
    logic test_bit;
  } bcc_out_t;

  // Time image, MSB first; bit 35 (weekday top) reads zero
  typedef struct packed {
    logic [7:0] year;
    logic [3:0] month;
    logic       pad;
    logic [2:0] dow;
    logic [7:0] day;
    logic [7:0] hour;
    logic [7:0] minute;
    logic [7:0] second;
  } bcc_time_t;

  // Per-item strobes from the top level to the datapath blocks
  typedef struct packed {
    logic       tick_en;
    logic       ctl_en;
    logic [7:0] code;
  } bcc_ctl_t;

  function automatic logic [7:0] bcd_inc(input logic [7:0] v);
    logic [7:0] s;
    s = v + 8'd1;
    if (s[3:0] >= 4'd10) begin
      s = {s[7:4], 4'h0} + 8'h10;
    end
    return s;
  endfunction

  // BCD day that ends the month (one past the last day), zero if month is invalid
  function automatic logic [7:0] month_end(input logic [3:0] m, input logic [7:0] y);
    logic [5:0] lsum;
    logic [7:0] e;
    lsum = {1'b0, y[7:4], 1'b0} + {2'b00, y[3:0]};
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: e = 8'h32;
      4'd2:                                       e = (lsum[1:0] == 2'd0) ? 8'h30 : 8'h29;
      4'd4, 4'd6, 4'd9, 4'd11:                    e = 8'h31;
      default:                                    e = 8'h00;
    endcase
    return e;
  endfunction

endpackage

### sv/bcc_time_core.sv
// Tick counter, test pulse and cascaded BCD calendar counters.
// Depends on bcc_pkg.
`timescale 1ns / 1ps

module bcc_time_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bcc_pkg::bcc_ctl_t ctl_i,
  input  logic [7:0]        tps_i,
  output bcc_pkg::bcc_time_t time_o,
  output logic              pulse_d_o
);
  import bcc_pkg::*;

  logic [7:0] cnt_q, cnt_d, cnt_inc;
  logic       pulse_q, pulse_d;
  logic [7:0] sec_q, sec_d, min_q, min_d, hour_q, hour_d, day_q, day_d, year_q, year_d;
  logic [2:0] dow_q, dow_d;
  logic [3:0] mon_q, mon_d;
  logic [7:0] sec_n, min_n, hour_n, day_n, year_n, end_day;
  logic [3:0] mon_n;

  always_comb begin
    cnt_d   = cnt_q;
    pulse_d = pulse_q;
    sec_d   = sec_q;
    min_d   = min_q;
    hour_d  = hour_q;
    day_d   = day_q;
    dow_d   = dow_q;
    mon_d   = mon_q;
    year_d  = year_q;
    cnt_inc = cnt_q + 8'd1;
    sec_n   = bcd_inc(sec_q);
    min_n   = bcd_inc(min_q);
    hour_n  = bcd_inc(hour_q);
    day_n   = bcd_inc(day_q);
    year_n  = bcd_inc(year_q);
    mon_n   = mon_q + 4'd1;
    end_day = month_end(mon_q, year_q);
    if (ctl_i.tick_en) begin
      pulse_d = ~pulse_q;
      cnt_d   = cnt_inc;
      if (cnt_inc >= tps_i) begin
        cnt_d = '0;
        sec_d = sec_n;
        if (sec_n >= SecLimit) begin
          sec_d = '0;
          min_d = min_n;
          if (min_n >= SecLimit) begin
            min_d  = '0;
            hour_d = hour_n;
            if (hour_n >= HourLimit) begin
              hour_d = '0;
              day_d  = day_n;
              dow_d  = (dow_q == DowLast) ? 3'd0 : dow_q + 3'd1;
              if (end_day != 8'h00 && day_n == end_day) begin
                day_d = 8'h01;
                mon_d = mon_n;
                if (mon_n == MonthWrap) begin
                  mon_d  = 4'd1;
                  year_d = (year_n == YearWrap) ? 8'h00 : year_n;
                end
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      pulse_q <= 1'b0;
      sec_q   <= '0;
      min_q   <= '0;
      hour_q  <= '0;
      day_q   <= DayReset;
      dow_q   <= DowReset;
      mon_q   <= MonthReset;
      year_q  <= YearReset;
    end else begin
      cnt_q   <= cnt_d;
      pulse_q <= pulse_d;
      sec_q   <= sec_d;
      min_q   <= min_d;
      hour_q  <= hour_d;
      day_q   <= day_d;
      dow_q   <= dow_d;
      mon_q   <= mon_d;
      year_q  <= year_d;
    end
  end

  assign time_o    = '{year: year_q, month: mon_q, pad: 1'b0, dow: dow_q,
                       day: day_q, hour: hour_q, minute: min_q, second: sec_q};
  assign pulse_d_o = pulse_d;

endmodule

### sv/bcc_readout.sv
// Serial readout: bit index register and latched data bit of the time image.
// Depends on bcc_pkg.
`timescale 1ns / 1ps

module bcc_readout (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bcc_pkg::bcc_ctl_t  ctl_i,
  input  bcc_pkg::bcc_time_t time_i,
  output logic               data_d_o
);
  import bcc_pkg::*;

  logic [5:0]           idx_q, idx_d;
  logic                 ser_q, ser_d;
  logic [ImageBits-1:0] image;

  assign image = time_i;

  always_comb begin
    idx_d = idx_q;
    ser_d = ser_q;
    if (ctl_i.ctl_en) begin
      unique case (ctl_i.code)
        CtlLoad: begin
          if (idx_q < 6'(ImageBits)) ser_d = image[idx_q];
        end
        CtlShift: begin
          if (idx_q != IdxMax) idx_d = idx_q + 6'd1;
        end
        CtlRestart: idx_d = '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      ser_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      ser_q <= ser_d;
    end
  end

  assign data_d_o = ser_d;

endmodule

### sv/bcd_calendar_clock_serial_readout.sv
// Top level of the BCD calendar clock with serial readout.
// Depends on bcc_pkg, bcc_time_core and bcc_readout.
`timescale 1ns / 1ps

// Each input item is a tick (action 0) or a control write (action 1). Ticks
// toggle the test bit and, every ticks_per_second ticks, advance the BCD
// seconds/minutes/hours, day, weekday, month and BCD year. Control codes:
// 0 latches the indexed bit of the 48-bit time image as the data bit, 2 steps
// the index (saturating at 63), 4 clears it. Every item yields one result item
// carrying the data and test bits as they stand after that item. Rate: one
// item per clock unless the sink stalls. An item lands in the input register,
// then one pass of the BCD carry chain / bit select updates the state and the
// result register in the same edge. The input side stalls only while the
// result register holds an item that the sink is stalling. ticks_per_second is
// written by the user via cfg_we_i / cfg_wdata_i only while idle; not enforced.

module bcd_calendar_clock_serial_readout (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  input  bcc_pkg::bcc_in_t  in_item_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  output bcc_pkg::bcc_out_t out_item_o,
  input  logic              out_stall_i
);
  import bcc_pkg::*;

  logic [7:0] tps_r_q;
  logic      s0_valid_q;
  bcc_in_t   s0_item_q;
  logic      s0_adv;
  logic      in_acc;
  logic      out_valid_q;
  bcc_out_t  out_item_q;
  bcc_ctl_t  ctl;
  bcc_time_t time_now;
  logic      pulse_d;
  logic      data_d;

  // Input stage moves on when the result register is free or being drained
  assign s0_adv     = s0_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s0_valid_q && !s0_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign ctl.tick_en = s0_adv && (s0_item_q.action == ActTick);
  assign ctl.ctl_en  = s0_adv && (s0_item_q.action == ActCtrl);
  assign ctl.code    = s0_item_q.control_code;

  // Config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_r_q <= TpsReset;
    end else if (cfg_we_i) begin
      tps_r_q <= cfg_wdata_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (in_acc) begin
      s0_valid_q <= 1'b1;
    end else if (s0_adv) begin
      s0_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) s0_item_q <= in_item_i;
  end

  bcc_time_core u_time (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .tps_i    (tps_r_q),
    .time_o   (time_now),
    .pulse_d_o(pulse_d)
  );

  bcc_readout u_readout (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .time_i  (time_now),
    .data_d_o(data_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s0_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_adv) begin
      out_item_q.data_bit <= data_d;
      out_item_q.test_bit <= pulse_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

### sv/bcc_checker.sv
// Port-level checks for the BCD calendar clock, bound to the top level.
// Depends on bcc_pkg and bcd_calendar_clock_serial_readout.
`timescale 1ns / 1ps

module bcc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input bcc_pkg::bcc_out_t out_item_o,
  input logic              out_stall_i
);

  // A stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result item changed while stalled");

  // Input never stalls while the result side is empty
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty result register");

  // An accepted item passes the input register and then reaches the result register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> ##1 out_valid_o)
    else $error("accepted item did not produce a result");

endmodule

bind bcd_calendar_clock_serial_readout bcc_checker u_bcc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_item_o (out_item_o),
  .out_stall_i(out_stall_i)
);
